// File: hdl/wbp_pkg.sv
// Shared types and constants for the wheel balance PID core.
// Holds field widths, register indexes, reset values and the stage control structs.
// No dependencies.
package wbp_pkg;

    // Field and state widths
    localparam int COUNT_W = 32;
    localparam int ERR_W   = 33;
    localparam int DIFF_W  = 34;
    localparam int SUM_W   = 48;
    localparam int GAIN_W  = 32;
    localparam int BASE_W  = 17;
    localparam int SPEED_W = 18;
    localparam int TERM_W  = 21;
    localparam int TOTAL_W = 23;
    localparam int CALC_W  = 24;
    localparam int OPND_W  = 48;
    localparam int HALF_W  = 18;
    localparam int PROD_W  = HALF_W + GAIN_W;
    localparam int FULL_W  = 2 * HALF_W + GAIN_W;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 32;

    // Pipeline depth: input, error, accumulate, magnitude, product, term, result
    localparam int STAGES = 7;

    // Saturation limits
    localparam logic signed [SUM_W-1:0]  SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [TERM_W-1:0]        TERM_CAP  = TERM_W'(1 << 20);
    localparam logic signed [CALC_W-1:0] SPEED_POS = CALC_W'(65536);
    localparam logic signed [CALC_W-1:0] SPEED_NEG = -CALC_W'(65536);

    // Reset values of the registers and the held speed
    localparam logic [BASE_W-1:0]  BASE_RST   = BASE_W'(19661);
    localparam logic [GAIN_W-1:0]  GAIN_P_RST = GAIN_W'(2619930);
    localparam logic [GAIN_W-1:0]  GAIN_I_RST = GAIN_W'(4295);
    localparam logic [GAIN_W-1:0]  GAIN_D_RST = GAIN_W'(68719);
    localparam logic signed [SPEED_W-1:0] HELD_RST = SPEED_W'(19661);

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_BASE_SPEED = 2'd0,
        REG_GAIN_P     = 2'd1,
        REG_GAIN_I     = 2'd2,
        REG_GAIN_D     = 2'd3
    } reg_index_t;

    // Load enables for the front stages
    typedef struct packed {
        logic load_in;
        logic load_err;
        logic load_acc;
        logic load_mag;
    } front_ctrl_t;

    // Load enables for one term unit
    typedef struct packed {
        logic load_prod;
        logic load_term;
    } term_ctrl_t;

endpackage

// File: hdl/wbp_front.sv
// Front stages of the wheel balance PID core: input capture, balance error,
// saturating error sum, derivative difference and operand magnitudes.
// Depends on wbp_pkg.
module wbp_front
    import wbp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  front_ctrl_t              ctrl,
    input  logic signed [COUNT_W-1:0] left_count,
    input  logic signed [COUNT_W-1:0] right_count,
    output logic signed [ERR_W-1:0]   err,
    output logic [COUNT_W-1:0]        mag_err,
    output logic [SUM_W-1:0]          mag_sum,
    output logic [ERR_W-1:0]          mag_diff
);

    logic signed [COUNT_W-1:0] left_reg;
    logic signed [COUNT_W-1:0] right_reg;
    logic signed [ERR_W-1:0]   err2_reg;
    logic signed [ERR_W-1:0]   err3_reg;
    logic signed [SUM_W-1:0]   sum3_reg;
    logic signed [DIFF_W-1:0]  diff3_reg;
    logic signed [ERR_W-1:0]   err4_reg;
    logic [COUNT_W-1:0]        mag_err4_reg;
    logic [SUM_W-1:0]          mag_sum4_reg;
    logic [ERR_W-1:0]          mag_diff4_reg;
    logic signed [SUM_W-1:0]   error_sum_reg;
    logic signed [ERR_W-1:0]   last_error_reg;

    logic [COUNT_W-1:0]        mag_left;
    logic [COUNT_W-1:0]        mag_right;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [DIFF_W-1:0]  diff_next;
    logic [SUM_W-1:0]          mag_sum_next;
    logic [DIFF_W-1:0]         mag_diff_wide;

    // Count magnitudes and their difference
    always_comb
    begin
        mag_left  = left_reg[COUNT_W-1]  ? COUNT_W'(-left_reg)  : left_reg;
        mag_right = right_reg[COUNT_W-1] ? COUNT_W'(-right_reg) : right_reg;
        err_next  = $signed({1'b0, mag_right}) - $signed({1'b0, mag_left});
    end

    // Saturating running sum and difference to the previous error
    always_comb
    begin
        sum_wide = {error_sum_reg[SUM_W-1], error_sum_reg}
                 + {{(SUM_W+1-ERR_W){err2_reg[ERR_W-1]}}, err2_reg};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_next = sum_wide[SUM_W-1:0];
        end
        diff_next = {err2_reg[ERR_W-1], err2_reg} - {last_error_reg[ERR_W-1], last_error_reg};
    end

    // Magnitudes of the sum and of the difference
    always_comb
    begin
        mag_sum_next  = sum3_reg[SUM_W-1] ? SUM_W'(-sum3_reg) : sum3_reg;
        mag_diff_wide = diff3_reg[DIFF_W-1] ? DIFF_W'(-diff3_reg) : diff3_reg;
    end

    // Pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            left_reg  <= left_count;
            right_reg <= right_count;
        end
        if (ctrl.load_err)
        begin
            err2_reg <= err_next;
        end
        if (ctrl.load_acc)
        begin
            err3_reg  <= err2_reg;
            sum3_reg  <= sum_next;
            diff3_reg <= diff_next;
        end
        if (ctrl.load_mag)
        begin
            err4_reg      <= err3_reg;
            mag_err4_reg  <= err3_reg[ERR_W-1] ? COUNT_W'(-err3_reg) : err3_reg[COUNT_W-1:0];
            mag_sum4_reg  <= mag_sum_next;
            mag_diff4_reg <= mag_diff_wide[ERR_W-1:0];
        end
    end

    // Advance the integral and derivative state once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end
        else if (ctrl.load_acc)
        begin
            error_sum_reg  <= sum_next;
            last_error_reg <= err2_reg;
        end
    end

    assign err      = err4_reg;
    assign mag_err  = mag_err4_reg;
    assign mag_sum  = mag_sum4_reg;
    assign mag_diff = mag_diff4_reg;

endmodule

// File: hdl/wbp_term.sv
// One scaled PID term: (operand * gain) >> 16, capped at 2^20.
// Two 18x32 partial products in one stage, sum, shift and cap in the next.
// Depends on wbp_pkg.
module wbp_term
    import wbp_pkg::*;
(
    input  logic                clk,
    input  term_ctrl_t          ctrl,
    input  logic [OPND_W-1:0]   operand,
    input  logic [GAIN_W-1:0]   gain,
    output logic [TERM_W-1:0]   term
);

    logic [PROD_W-1:0]    prod_hi_reg;
    logic [PROD_W-1:0]    prod_lo_reg;
    logic                 big_reg;
    logic [TERM_W-1:0]    term_reg;

    logic                 big_next;
    logic [FULL_W-1:0]    full_prod;
    logic [FULL_W-17:0]   shifted;
    logic [TERM_W-1:0]    term_next;

    // Any operand at or above 2^36 with a non-zero gain always hits the cap
    assign big_next = (|operand[OPND_W-1:2*HALF_W]) && (|gain);

    // Recombine the partial products and cap
    always_comb
    begin
        full_prod = (FULL_W'(prod_hi_reg) << HALF_W) + FULL_W'(prod_lo_reg);
        shifted   = full_prod[FULL_W-1:16];
        if (big_reg || (shifted > (FULL_W-16)'(TERM_CAP)))
        begin
            term_next = TERM_CAP;
        end
        else
        begin
            term_next = shifted[TERM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            prod_hi_reg <= PROD_W'(operand[2*HALF_W-1:HALF_W]) * PROD_W'(gain);
            prod_lo_reg <= PROD_W'(operand[HALF_W-1:0]) * PROD_W'(gain);
            big_reg     <= big_next;
        end
        if (ctrl.load_term)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

// File: hdl/wheel_balance_pid_core.sv
// Top level of the wheel balance PID core: stream handshake, configuration
// registers, pipeline control and the left speed result stage.
// Depends on wbp_pkg, wbp_front and wbp_term.

// The core takes one transaction of left and right encoder counts per clock
// cycle while its input is ready and returns one transaction of corrected
// left speed and balance error for each, in order. The seven stages (input,
// error, accumulate, magnitude, product, term, result) each hold their own
// valid bit, so a stalled output only holds back the stages behind it while
// earlier bubbles are filled. The integral sum and previous error advance in
// the accumulate stage and the held speed in the result stage, so back-to-back
// transactions see exactly the state their predecessors left. Configuration
// writes take effect at once and should be made while no transaction is in
// flight.
module wheel_balance_pid_core
    import wbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // Input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,   // left_count[31:0], right_count[63:32]
    // Output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata    // left_speed[17:0], balance_error[50:18]
);

    logic [BASE_W-1:0]          base_speed_reg;
    logic [GAIN_W-1:0]          gain_p_reg;
    logic [GAIN_W-1:0]          gain_i_reg;
    logic [GAIN_W-1:0]          gain_d_reg;

    logic [STAGES-1:0]          valid_reg;
    logic [STAGES:0]            rdy;
    logic [STAGES-1:0]          load;

    front_ctrl_t                front_ctrl;
    term_ctrl_t                 term_ctrl;

    logic signed [ERR_W-1:0]    err4;
    logic [COUNT_W-1:0]         mag_err4;
    logic [SUM_W-1:0]           mag_sum4;
    logic [ERR_W-1:0]           mag_diff4;
    logic [TERM_W-1:0]          term_p;
    logic [TERM_W-1:0]          term_i;
    logic [TERM_W-1:0]          term_d;

    logic signed [ERR_W-1:0]    err5_reg;
    logic signed [ERR_W-1:0]    err6_reg;
    logic signed [ERR_W-1:0]    err_out_reg;
    logic signed [SPEED_W-1:0]  speed_reg;
    logic signed [SPEED_W-1:0]  held_speed_reg;

    logic [TOTAL_W-1:0]         total;
    logic signed [CALC_W-1:0]   speed_raw;
    logic signed [SPEED_W-1:0]  speed_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_speed_reg <= BASE_RST;
            gain_p_reg     <= GAIN_P_RST;
            gain_i_reg     <= GAIN_I_RST;
            gain_d_reg     <= GAIN_D_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_BASE_SPEED: base_speed_reg <= cfg_data[BASE_W-1:0];
                REG_GAIN_P:     gain_p_reg     <= cfg_data;
                REG_GAIN_I:     gain_i_reg     <= cfg_data;
                REG_GAIN_D:     gain_d_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Ready ripples back from the output; a stage takes a new entry when empty or draining
    always_comb
    begin
        rdy[STAGES] = m_axis_tready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        load[0] = rdy[0] && s_axis_tvalid;
        for (int k = 1; k < STAGES; k++)
        begin
            load[k] = rdy[k] && valid_reg[k-1];
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        front_ctrl.load_in   = load[0];
        front_ctrl.load_err  = load[1];
        front_ctrl.load_acc  = load[2];
        front_ctrl.load_mag  = load[3];
        term_ctrl.load_prod  = load[4];
        term_ctrl.load_term  = load[5];
    end

    wbp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (front_ctrl),
        .left_count  (s_axis_tdata[31:0]),
        .right_count (s_axis_tdata[63:32]),
        .err         (err4),
        .mag_err     (mag_err4),
        .mag_sum     (mag_sum4),
        .mag_diff    (mag_diff4)
    );

    wbp_term u_term_p (
        .clk     (clk),
        .ctrl    (term_ctrl),
        .operand (OPND_W'(mag_err4)),
        .gain    (gain_p_reg),
        .term    (term_p)
    );

    wbp_term u_term_i (
        .clk     (clk),
        .ctrl    (term_ctrl),
        .operand (mag_sum4),
        .gain    (gain_i_reg),
        .term    (term_i)
    );

    wbp_term u_term_d (
        .clk     (clk),
        .ctrl    (term_ctrl),
        .operand (OPND_W'(mag_diff4)),
        .gain    (gain_d_reg),
        .term    (term_d)
    );

    // Carry the error alongside the term units
    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            err5_reg <= err4;
        end
        if (load[5])
        begin
            err6_reg <= err5_reg;
        end
    end

    // Add or subtract the correction by error sign, hold on zero error, saturate
    always_comb
    begin
        total     = TOTAL_W'(term_p) + TOTAL_W'(term_i) + TOTAL_W'(term_d);
        speed_raw = $signed(CALC_W'(base_speed_reg));
        if (err6_reg[ERR_W-1])
        begin
            speed_raw = speed_raw - $signed(CALC_W'(total));
        end
        else if (|err6_reg)
        begin
            speed_raw = speed_raw + $signed(CALC_W'(total));
        end
        else
        begin
            speed_raw = CALC_W'(held_speed_reg);
        end

        if (speed_raw > SPEED_POS)
        begin
            speed_next = SPEED_W'(SPEED_POS);
        end
        else if (speed_raw < SPEED_NEG)
        begin
            speed_next = SPEED_W'(SPEED_NEG);
        end
        else
        begin
            speed_next = speed_raw[SPEED_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            speed_reg   <= speed_next;
            err_out_reg <= err6_reg;
        end
    end

    // Held speed for the zero error case
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_speed_reg <= HELD_RST;
        end
        else if (load[6])
        begin
            held_speed_reg <= speed_next;
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = valid_reg[STAGES-1];
    assign m_axis_tdata  = {5'b0, err_out_reg, speed_reg};

endmodule
